### rtl/core/aesbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesbc_pkg
// Constants, S-box tables and GF(2^8) column helpers for the AES block cipher.
// ----------------------------------------------------------------------------
package aesbc_pkg;

    localparam int RKW_DEFAULT = 60;
    localparam int RKW_MIN     = 44;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
    localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD3 = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // MixColumns on one column, row 0 in the top byte
    function automatic logic [31:0] mix_col(input logic [31:0] col);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [31:0] res;
        for (int r = 0; r < 4; r++) begin
            a[r]  = col[31 - 8*r -: 8];
            x2[r] = xtime(a[r]);
        end
        for (int r = 0; r < 4; r++) begin
            res[31 - 8*r -: 8] = x2[r] ^ x2[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
        end
        return res;
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [31:0] res;
        for (int r = 0; r < 4; r++) begin
            a[r]  = col[31 - 8*r -: 8];
            x2[r] = xtime(a[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
        end
        // 14, 11, 13, 9
        for (int r = 0; r < 4; r++) begin
            res[31 - 8*r -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                               ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                               ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                               ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/core/aesbc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module aesbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/core/aes_block_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 encrypt and decrypt, one state column per cycle.
// ----------------------------------------------------------------------------
// Usage:
//  - Key and key size are written through the cfg port while the block is
//    idle; the user is bound by this, the block itself does not enforce it.
//    Each accepted write to a key register rebuilds the round-key schedule,
//    one 32-bit word per cycle. After reset the schedule of the all-zero
//    128-bit key is built first; s_ready stays low while it is being built.
//  - Input items (s_*) carry a block and an action bit (0 encrypt, 1 decrypt).
//  - Each round is processed one column per cycle through the key RAM read
//    port, whose registered data feeds the column datapath; after the last
//    round a finish step loads the output register when free and raises
//    m_valid. One item at a time; the next item can be accepted in the same
//    cycle that m_valid rises.
//  - Results are held in an output register; a new item is accepted while a
//    result waits. If the receiver stalls and the next result is done, the
//    core holds it until the output register frees.
//  - Reset clears handshakes and the key registers.
// ----------------------------------------------------------------------------
module aes_block_cipher
    import aesbc_pkg::*;
#(
    parameter int ROUND_KEY_WORDS = RKW_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [63:0] s_block_hi,
    input  wire logic [63:0] s_block_lo,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [63:0] m_result_hi,
    output logic      [63:0] m_result_lo
);

    localparam int AW = $clog2(ROUND_KEY_WORDS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [1:0]   key_size_reg, key_size_next;
    logic [63:0]  key_word_reg [4];
    logic [63:0]  key_word_next [4];
    logic [AW-1:0] exp_idx_reg, exp_idx_next;
    logic [2:0]   exp_mod_reg, exp_mod_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [31:0]  win_reg [8];
    logic [31:0]  win_next [8];
    logic [127:0] blk_reg, blk_next;
    logic [127:0] tmp_reg, tmp_next;
    logic         dec_reg, dec_next;
    logic [3:0]   a_round_reg, a_round_next;
    logic [1:0]   a_col_reg, a_col_next;
    logic         a_valid_reg, a_valid_next;
    logic [3:0]   b_round_reg;
    logic [1:0]   b_col_reg;
    logic         b_valid_reg;
    logic         m_valid_reg, m_valid_next;
    logic [127:0] res_reg, res_next;

    logic [3:0]   nk, nr;
    logic [3:0]   a_key_round;
    logic         ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]  ram_wdata, ram_rdata;
    logic [31:0]  exp_word, exp_temp, exp_old;
    logic [31:0]  col_plain, col_sub, col_isub, col_out, col_x, col_y;
    logic         add_only, do_mix, rebuild;

    // key length from the size code, cut to the largest that fits the schedule store
    always_comb begin
        unique case (key_size_reg)
            2'd0:    nk = 4'd4;
            2'd1:    nk = 4'd6;
            default: nk = 4'd8;
        endcase
        if (nk == 4'd8 && ROUND_KEY_WORDS < 60) nk = 4'd6;
        if (nk == 4'd6 && ROUND_KEY_WORDS < 52) nk = 4'd4;
    end
    assign nr = nk + 4'd6;

    // ---- key expansion word ----
    assign exp_temp = win_reg[0];
    assign exp_old  = win_reg[3'(nk - 4'd1)];
    always_comb begin
        if (exp_idx_reg < AW'(nk)) begin
            exp_word = exp_idx_reg[0] ? key_word_reg[exp_idx_reg[2:1]][31:0]
                                      : key_word_reg[exp_idx_reg[2:1]][63:32];
        end else if (exp_mod_reg == 3'd0) begin
            exp_word = exp_old ^ sub_word({exp_temp[23:0], exp_temp[31:24]})
                     ^ {rcon_reg, 24'h0};
        end else if (nk == 4'd8 && exp_mod_reg == 3'd4) begin
            exp_word = exp_old ^ sub_word(exp_temp);
        end else begin
            exp_word = exp_old ^ exp_temp;
        end
    end

    // ---- round column datapath ----
    assign a_key_round = dec_reg ? (nr - a_round_reg) : a_round_reg;
    assign ram_raddr   = AW'({a_key_round, a_col_reg});
    assign ram_we      = (state_reg == ST_EXPAND);
    assign ram_waddr   = exp_idx_reg;
    assign ram_wdata   = exp_word;

    always_comb begin
        logic [1:0] ce, cd;
        for (int r = 0; r < 4; r++) begin
            ce = b_col_reg + 2'(r);
            cd = b_col_reg - 2'(r);
            col_plain[31 - 8*r -: 8] = blk_reg[{~{b_col_reg, 2'(r)}, 3'b000} +: 8];
            col_sub[31 - 8*r -: 8]   = SBOX[blk_reg[{~{ce, 2'(r)}, 3'b000} +: 8]];
            col_isub[31 - 8*r -: 8]  = INV_SBOX[blk_reg[{~{cd, 2'(r)}, 3'b000} +: 8]];
        end
    end

    assign add_only = (b_round_reg == 4'd0);
    assign do_mix   = !add_only && (b_round_reg != nr);
    assign col_x    = add_only ? col_plain : col_sub;
    assign col_y    = (add_only ? col_plain : col_isub) ^ ram_rdata;
    always_comb begin
        if (dec_reg) begin
            col_out = do_mix ? inv_mix_col(col_y) : col_y;
        end else begin
            col_out = (do_mix ? mix_col(col_x) : col_x) ^ ram_rdata;
        end
    end

    assign rebuild = cfg_we && (cfg_idx == REG_KEY_SIZE || cfg_idx == REG_KEY_WORD0
                             || cfg_idx == REG_KEY_WORD1 || cfg_idx == REG_KEY_WORD2
                             || cfg_idx == REG_KEY_WORD3);

    always_comb begin
        state_next    = state_reg;
        key_size_next = key_size_reg;
        key_word_next = key_word_reg;
        exp_idx_next  = exp_idx_reg;
        exp_mod_next  = exp_mod_reg;
        rcon_next     = rcon_reg;
        win_next      = win_reg;
        blk_next      = blk_reg;
        tmp_next      = tmp_reg;
        dec_next      = dec_reg;
        a_round_next  = a_round_reg;
        a_col_next    = a_col_reg;
        a_valid_next  = a_valid_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    blk_next     = {s_block_hi, s_block_lo};
                    dec_next     = s_action;
                    a_round_next = 4'd0;
                    a_col_next   = 2'd0;
                    a_valid_next = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_EXPAND: begin
                win_next[0] = exp_word;
                for (int k = 1; k < 8; k++) win_next[k] = win_reg[k-1];
                if (exp_idx_reg >= AW'(nk) && exp_mod_reg == 3'd0) begin
                    rcon_next = xtime(rcon_reg);
                end
                exp_mod_next = (exp_mod_reg == 3'(nk - 4'd1)) ? 3'd0 : exp_mod_reg + 3'd1;
                exp_idx_next = exp_idx_reg + AW'(1);
                if (exp_idx_reg == AW'({nr, 2'b11})) state_next = ST_IDLE;
            end
            ST_RUN: begin
                if (a_valid_reg) begin
                    a_col_next = a_col_reg + 2'd1;
                    if (a_col_reg == 2'd3) begin
                        if (a_round_reg == nr) a_valid_next = 1'b0;
                        else a_round_next = a_round_reg + 4'd1;
                    end
                end
                if (b_valid_reg) begin
                    tmp_next[{~b_col_reg, 5'b00000} +: 32] = col_out;
                    if (b_col_reg == 2'd3) begin
                        blk_next = tmp_next;
                        if (b_round_reg == nr) state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    res_next     = blk_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg_we) begin
            unique case (cfg_idx)
                REG_KEY_SIZE:  key_size_next    = cfg_wdata[1:0];
                REG_KEY_WORD0: key_word_next[0] = cfg_wdata;
                REG_KEY_WORD1: key_word_next[1] = cfg_wdata;
                REG_KEY_WORD2: key_word_next[2] = cfg_wdata;
                REG_KEY_WORD3: key_word_next[3] = cfg_wdata;
                default: ;
            endcase
        end
        if (rebuild) begin
            state_next   = ST_EXPAND;
            exp_idx_next = '0;
            exp_mod_next = 3'd0;
            rcon_next    = 8'h01;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_EXPAND;
            key_size_reg <= 2'd0;
            for (int k = 0; k < 4; k++) key_word_reg[k] <= '0;
            exp_idx_reg  <= '0;
            exp_mod_reg  <= 3'd0;
            rcon_reg     <= 8'h01;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            key_size_reg <= key_size_next;
            key_word_reg <= key_word_next;
            exp_idx_reg  <= exp_idx_next;
            exp_mod_reg  <= exp_mod_next;
            rcon_reg     <= rcon_next;
            a_valid_reg  <= a_valid_next;
            b_valid_reg  <= a_valid_reg && (state_reg == ST_RUN);
            m_valid_reg  <= m_valid_next;
        end
        win_reg     <= win_next;
        blk_reg     <= blk_next;
        tmp_reg     <= tmp_next;
        dec_reg     <= dec_next;
        a_round_reg <= a_round_next;
        a_col_reg   <= a_col_next;
        b_round_reg <= a_round_reg;
        b_col_reg   <= a_col_reg;
        res_reg     <= res_next;
    end

    aesbc_ram #(
        .WIDTH (32),
        .DEPTH (ROUND_KEY_WORDS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_result_hi = res_reg[127:64];
    assign m_result_lo = res_reg[63:0];

`ifndef SYNTHESIS
    // one item in flight: no second acceptance straight after the first
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while core busy");

    // a result only appears from the finish step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    // a key write stops acceptance while the schedule is rebuilt
    a_rebuild_block: assert property (@(posedge aclk) disable iff (!aresetn)
        rebuild |=> !s_ready)
        else $error("item accepted during key expansion");
`endif

endmodule
`default_nettype wire

### tb/aes_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_tb
// Self-checking bench for the AES block cipher. The key is reloaded between
// phases over the configuration port. A behavioural AES model predicts each
// result block, and results are compared in order. The directed vectors
// include the FIPS-197 examples. Random blocks follow with random input
// gaps and output back-pressure, except in phases run without stalls.
// ----------------------------------------------------------------------------
module aes_block_cipher_tb
    import aesbc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit ACT_ENC = 1'b0;
    localparam bit ACT_DEC = 1'b1;
    localparam int SETTLE  = 80;     // worst-case item latency plus slack
    localparam int LIMIT   = 3000;   // cycles without any transfer
    localparam int PHASES  = 12;
    localparam int PER_PHASE = 96;

    typedef struct {
        logic [1:0]  ks;
        logic [63:0] key [4];
        bit          oob;        // also write an unmapped register
        bit          action;
        logic [63:0] hi, lo;
        bit          known;
        logic [127:0] want;
    } vec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = REG_KEY_SIZE;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [63:0] s_block_hi = '0, s_block_lo = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_hi, m_result_lo;

    // shadow of the key registers
    logic [1:0]  key_size_sh = '0;
    logic [63:0] key_sh [4] = '{default: '0};

    logic [127:0] blocks_due [$];
    int errors = 0, n_items = 0, n_results = 0, n_cfg = 0, idle_cycles = 0;
    int n_loads = 0;
    bit no_stall = 1'b0;
    int out_hold = 0;

    aes_block_cipher i_dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [127:0] aes_block(input bit dec, input logic [127:0] blk);
        logic [31:0] w [60];
        logic [7:0]  s [16];
        logic [7:0]  t [16];
        logic [7:0]  rc, b;
        logic [31:0] tmp;
        logic [7:0]  mf [4];
        logic [127:0] res;
        int nk, nr, rnd;
        rc = 8'h01;
        nk = (key_size_sh == 2'd0) ? 4 : (key_size_sh == 2'd1) ? 6 : 8;
        nr = nk + 6;
        for (int i = 0; i < nk; i++) w[i] = key_sh[i/2][(i % 2) ? 31 : 63 -: 32];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            tmp = w[i-1];
            if (i % nk == 0) begin
                tmp = {tmp[23:0], tmp[31:24]};
                tmp = {SBOX[tmp[31:24]], SBOX[tmp[23:16]], SBOX[tmp[15:8]], SBOX[tmp[7:0]]}
                      ^ {rc, 24'h0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end else if (nk > 6 && i % nk == 4) begin
                tmp = {SBOX[tmp[31:24]], SBOX[tmp[23:16]], SBOX[tmp[15:8]], SBOX[tmp[7:0]]};
            end
            w[i] = w[i-nk] ^ tmp;
        end
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
        if (dec) mf = '{8'd14, 8'd11, 8'd13, 8'd9};
        else mf = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int step = 0; step <= nr; step++) begin
            rnd = dec ? nr - step : step;
            if (step > 0) begin
                // byte substitution and row shift
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[r + 4*c] = dec ? INV_SBOX[s[r + 4*((c + 4 - r) % 4)]]
                                         : SBOX[s[r + 4*((c + r) % 4)]];
                s = t;
            end
            // forward: mix then key; inverse: key then mix
            if (!dec && step > 0 && step < nr) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        b = '0;
                        for (int k = 0; k < 4; k++) b ^= gf_mul(mf[(k + 4 - r) % 4], s[4*c + k]);
                        t[4*c + r] = b;
                    end
                s = t;
            end
            for (int i = 0; i < 16; i++) s[i] ^= w[rnd*4 + i/4][31 - 8*(i % 4) -: 8];
            if (dec && step > 0 && step < nr) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        b = '0;
                        for (int k = 0; k < 4; k++) b ^= gf_mul(mf[(k + 4 - r) % 4], s[4*c + k]);
                        t[4*c + r] = b;
                    end
                s = t;
            end
        end
        for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    // result side: checks and random stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (blocks_due.size() == 0) begin
                    errors++;
                    $display("[%0t] unexpected result item %h_%h", $realtime,
                             m_result_hi, m_result_lo);
                end else begin
                    logic [127:0] exp_blk;
                    exp_blk = blocks_due.pop_front();
                    if (m_result_hi !== exp_blk[127:64])
                        report_mismatch("result_hi", m_result_hi, exp_blk[127:64]);
                    if (m_result_lo !== exp_blk[63:0])
                        report_mismatch("result_lo", m_result_lo, exp_blk[63:0]);
                end
                out_hold = no_stall ? 0 : $urandom_range(0, 9);
            end else if (out_hold > 0) begin
                out_hold--;
            end
            m_ready <= (out_hold == 0);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else if (idle_cycles >= LIMIT) begin
            $display("watchdog expired with %0d result items outstanding", blocks_due.size());
            $display("aes_block_cipher_tb: FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic wait_quiet();
        while (blocks_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // cfg_we left high; caller lowers it after the last write
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        n_cfg++;
        if (idx == REG_KEY_SIZE) key_size_sh = data[1:0];
        else if (idx <= REG_KEY_WORD3) key_sh[idx - REG_KEY_WORD0] = data;
    endtask

    task automatic load_key(input logic [1:0] ks, input logic [63:0] key [4], input bit oob);
        wait_quiet();
        n_loads++;
        cfg_write(REG_KEY_SIZE, {$urandom, $urandom} & ~64'h3 | ks);
        cfg_write(REG_KEY_WORD0, key[0]);
        cfg_write(REG_KEY_WORD1, key[1]);
        cfg_write(REG_KEY_WORD2, key[2]);
        cfg_write(REG_KEY_WORD3, key[3]);
        if (oob) cfg_write(REG_KEY_WORD3 + 3'($urandom_range(1, 3)), {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task automatic send_block(input bit act, input logic [63:0] hi, input logic [63:0] lo,
                              input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_block_hi <= hi;
        s_block_lo <= lo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        blocks_due.push_back(aes_block(act, {hi, lo}));
        n_items++;
    endtask

    vec_t vecs [$];

    task automatic add_vec(input logic [1:0] ks, input logic [255:0] k, input bit oob,
                           input bit act, input logic [127:0] blk, input bit known,
                           input logic [127:0] want);
        vec_t v;
        v.ks = ks;
        for (int i = 0; i < 4; i++) v.key[i] = k[255 - 64*i -: 64];
        v.oob = oob; v.action = act; v.hi = blk[127:64]; v.lo = blk[63:0];
        v.known = known; v.want = want;
        vecs.push_back(v);
    endtask

    initial begin
        logic [63:0] rk [4];
        logic [255:0] fips_key;
        bit changed;
        fips_key = 256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;

        // zero key straight out of reset
        add_vec(2'd0, '0, 0, ACT_ENC, '0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        add_vec(2'd0, '0, 0, ACT_DEC, '0, 0, '0);
        add_vec(2'd0, '0, 0, ACT_ENC, '1, 0, '0);
        add_vec(2'd0, '0, 0, ACT_DEC, '1, 0, '0);
        add_vec(2'd0, fips_key, 0, ACT_ENC, 128'h00112233445566778899aabbccddeeff,
                1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
        add_vec(2'd0, fips_key, 0, ACT_DEC, 128'h69c4e0d86a7b0430d8cdb78070b4c55a,
                1, 128'h00112233445566778899aabbccddeeff);
        add_vec(2'd1, fips_key, 0, ACT_ENC, 128'h00112233445566778899aabbccddeeff,
                1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191);
        add_vec(2'd1, fips_key, 0, ACT_DEC, 128'hdda97ca4864cdfe06eaf70a0ec0d7191,
                1, 128'h00112233445566778899aabbccddeeff);
        // unused key word changed: 192-bit result must not move
        add_vec(2'd1, {fips_key[255:64], 64'hdeadbeefcafef00d}, 0, ACT_ENC,
                128'h00112233445566778899aabbccddeeff, 1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191);
        add_vec(2'd2, fips_key, 0, ACT_ENC, 128'h00112233445566778899aabbccddeeff,
                1, 128'h8ea2b7ca516745bfeafc49904b496089);
        add_vec(2'd2, fips_key, 0, ACT_DEC, 128'h8ea2b7ca516745bfeafc49904b496089,
                1, 128'h00112233445566778899aabbccddeeff);
        // size code 3 behaves as a 256-bit key; unmapped write is a no-op
        add_vec(2'd3, fips_key, 1, ACT_ENC, 128'h00112233445566778899aabbccddeeff,
                1, 128'h8ea2b7ca516745bfeafc49904b496089);
        add_vec(2'd2, '1, 0, ACT_ENC, '1, 0, '0);
        add_vec(2'd2, '1, 0, ACT_DEC, '0, 0, '0);
        add_vec(2'd1, '1, 0, ACT_ENC, 128'h8000000000000001_8000000000000001, 0, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (vecs[n]) begin
            changed = vecs[n].oob || (n > 0 && vecs[n].ks != key_size_sh);
            for (int i = 0; i < 4; i++) if (vecs[n].key[i] != key_sh[i]) changed = 1;
            if (changed) begin
                s_valid <= 1'b0;
                load_key(vecs[n].ks, vecs[n].key, vecs[n].oob);
            end
            if (vecs[n].known && aes_block(vecs[n].action, {vecs[n].hi, vecs[n].lo}) !==
                vecs[n].want) begin
                errors++;
                $display("directed item %0d: model disagrees with published vector", n);
            end
            send_block(vecs[n].action, vecs[n].hi, vecs[n].lo, 1'b1);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            logic [1:0] ks;
            s_valid <= 1'b0;
            ks = 2'($urandom_range(0, 3));
            for (int i = 0; i < 4; i++) rk[i] = {$urandom, $urandom};
            if (ph == 0) begin ks = 2'd2; rk = '{default: '0}; end
            if (ph == 1) begin ks = 2'd1; rk = '{default: '1}; end
            load_key(ks, rk, $urandom_range(0, 3) == 0);
            no_stall = (ph % 4 == 2);
            for (int i = 0; i < PER_PHASE; i++) begin
                logic [63:0] hi, lo;
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0: hi = '0;
                    1: lo = '1;
                    default: ;
                endcase
                // in phase 3, let the pipeline drain completely once mid-phase
                if (ph == 3 && i == PER_PHASE / 2) begin
                    s_valid <= 1'b0;
                    while (blocks_due.size() != 0) @(posedge aclk);
                end
                send_block($urandom_range(0, 1), hi, lo, !no_stall);
            end
        end
        s_valid <= 1'b0;
        no_stall = 1'b0;

        while (blocks_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d blocks (both actions, all key sizes) over %0d key loads,",
                 n_items, n_loads);
        $display("%0d register writes, %0d result items checked, %0d errors",
                 n_cfg, n_results, errors);
        if (errors == 0)
            $display("aes_block_cipher_tb: PASS");
        else
            $display("aes_block_cipher_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/aesbc_pkg.sv
rtl/core/aesbc_ram.sv
rtl/core/aes_block_cipher.sv
tb/aes_block_cipher_tb.sv
